FILE: rtl/kfau_pkg.sv
// Shared types, constants and field tables for the Koblitz field arithmetic unit.
// Depends on nothing; used by the interfaces and the top level.
package kfau_pkg;

   localparam int WORD_BITS = 32;
   localparam int MAX_WORDS = 18;
   localparam int VEC_BITS  = WORD_BITS * MAX_WORDS;

   typedef logic [VEC_BITS-1:0]  vec_type;
   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [4:0]           widx_type;
   typedef logic [2:0]           fsel_type;
   typedef logic [9:0]           deg_type;

   // operation codes
   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_MUL = 2'd1;
   localparam logic [1:0] FUNC_SQR = 2'd2;
   localparam logic [1:0] FUNC_INV = 2'd3;

   // field codes
   localparam fsel_type F_K163 = 3'd0;
   localparam fsel_type F_K233 = 3'd1;
   localparam fsel_type F_K283 = 3'd2;
   localparam fsel_type F_K409 = 3'd3;
   localparam fsel_type F_K571 = 3'd4;

   // codes above K571 act as K571
   function automatic fsel_type fld_norm(input fsel_type f);
      return (f > F_K571) ? F_K571 : f;
   endfunction

   function automatic deg_type fld_deg(input fsel_type f);
      case (f)
         F_K163:  return 10'd163;
         F_K233:  return 10'd233;
         F_K283:  return 10'd283;
         F_K409:  return 10'd409;
         default: return 10'd571;
      endcase
   endfunction

   function automatic widx_type fld_words(input fsel_type f);
      case (f)
         F_K163:  return 5'd6;
         F_K233:  return 5'd8;
         F_K283:  return 5'd9;
         F_K409:  return 5'd13;
         default: return 5'd18;
      endcase
   endfunction

   // ones on every bit below the field degree
   function automatic vec_type fld_mask(input fsel_type f);
      case (f)
         F_K163:  return {{(VEC_BITS-163){1'b0}}, {163{1'b1}}};
         F_K233:  return {{(VEC_BITS-233){1'b0}}, {233{1'b1}}};
         F_K283:  return {{(VEC_BITS-283){1'b0}}, {283{1'b1}}};
         F_K409:  return {{(VEC_BITS-409){1'b0}}, {409{1'b1}}};
         default: return {{(VEC_BITS-571){1'b0}}, {571{1'b1}}};
      endcase
   endfunction

   // low terms of the field polynomial
   function automatic vec_type fld_taps(input fsel_type f);
      case (f)
         F_K163:  return VEC_BITS'(8'hC9);
         F_K233:  return VEC_BITS'(1) | (VEC_BITS'(1) << 74);
         F_K283:  return VEC_BITS'(13'h10A1);
         F_K409:  return VEC_BITS'(1) | (VEC_BITS'(1) << 87);
         default: return VEC_BITS'(11'h425);
      endcase
   endfunction

   // coefficient of x^(m-1)
   function automatic logic fld_msb(input vec_type v, input fsel_type f);
      case (f)
         F_K163:  return v[162];
         F_K233:  return v[232];
         F_K283:  return v[282];
         F_K409:  return v[408];
         default: return v[570];
      endcase
   endfunction

   // move x^(m-1) up to the top bit for MSB-first scanning
   function automatic vec_type fld_align(input vec_type v, input fsel_type f);
      case (f)
         F_K163:  return v << (VEC_BITS - 163);
         F_K233:  return v << (VEC_BITS - 233);
         F_K283:  return v << (VEC_BITS - 283);
         F_K409:  return v << (VEC_BITS - 409);
         default: return v << (VEC_BITS - 571);
      endcase
   endfunction

endpackage

FILE: rtl/kfau_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on kfau_pkg.
interface kfau_req_if
   import kfau_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [1:0] func;
   word_type   operand_a_word;
   word_type   operand_b_word;
   widx_type   word_index;
   logic       last_word;

   modport source(output valid, func, operand_a_word, operand_b_word, word_index, last_word,
                  input ready);
   modport sink(input valid, func, operand_a_word, operand_b_word, word_index, last_word,
                output ready);
endinterface

interface kfau_rsp_if
   import kfau_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type result_word;
   widx_type result_index;
   logic     result_last;
   logic     error;

   modport source(output valid, result_word, result_index, result_last, error,
                  input ready);
   modport sink(input valid, result_word, result_index, result_last, error,
                output ready);
endinterface

FILE: rtl/koblitz_field_arithmetic_unit_top.sv
// Top level of the Koblitz field arithmetic unit: operand stores, bit-serial
// multiplier with interleaved reduction, and the operation sequencer.
// Depends on kfau_pkg and the kfau_req_if / kfau_rsp_if interfaces.

// Operand words are taken one per cycle; the item marked last starts the
// operation and no new item is taken until every result word has gone.
// Multiply and square run the bit-serial MSB-first multiplier. Inversion
// is a ^ (2^m - 2) by square-and-multiply on the same multiplier, in
// 2m - 3 passes for a field of degree m. Inverting zero answers at once
// with zero words and the error flag. Results then leave one word per
// cycle while the receiver is ready, as many words as the field needs
// (6 to 18).
module koblitz_field_arithmetic_unit_top
   import kfau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   kfau_req_if.sink     req_ch,
   kfau_rsp_if.source   rsp_ch,
   input  logic         csr_we,
   input  logic [2:0]   csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_KICK  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   fsel_type    field_ff;
   vec_type     a_ff, b_ff;
   vec_type     acc_ff, acc_in;
   vec_type     x_ff, x_in;
   vec_type     y_ff, y_in;
   logic [1:0]  func_ff, func_in;
   deg_type     cnt_ff, cnt_in;
   logic [10:0] ops_ff, ops_in;
   logic        sq_ff, sq_in;
   logic        err_ff, err_in;
   widx_type    oidx_ff, oidx_in;

   fsel_type    fsel;
   vec_type     fmask, a_m, b_m, step;
   logic        req_hs, rsp_hs;

   assign fsel   = fld_norm(field_ff);
   assign fmask  = fld_mask(fsel);
   assign a_m    = a_ff & fmask;
   assign b_m    = b_ff & fmask;
   assign req_hs = req_ch.valid & req_ch.ready;
   assign rsp_hs = rsp_ch.valid & rsp_ch.ready;

   // one multiplier step: acc*x mod f, plus y when the scanned bit is set
   always_comb begin
      step = (acc_ff << 1) & fmask;
      if (fld_msb(acc_ff, fsel)) begin
         step = step ^ fld_taps(fsel);
      end
      if (x_ff[VEC_BITS-1]) begin
         step = step ^ y_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      func_in  = func_ff;
      cnt_in   = cnt_ff;
      ops_in   = ops_ff;
      sq_in    = sq_ff;
      err_in   = err_ff;
      oidx_in  = oidx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_hs && req_ch.last_word) begin
               func_in  = req_ch.func;
               state_in = S_START;
            end
         end
         S_START: begin
            err_in  = 1'b0;
            oidx_in = '0;
            sq_in   = 1'b1;
            acc_in  = a_m;
            case (func_ff)
               FUNC_ADD: begin
                  acc_in   = a_m ^ b_m;
                  state_in = S_OUT;
               end
               FUNC_INV: begin
                  if (a_m == '0) begin
                     err_in   = 1'b1;
                     acc_in   = '0;
                     state_in = S_OUT;
                  end else begin
                     ops_in   = 11'({fld_deg(fsel), 1'b0}) - 11'd3;
                     state_in = S_KICK;
                  end
               end
               default: begin
                  ops_in   = 11'd1;
                  state_in = S_KICK;
               end
            endcase
         end
         S_KICK: begin
            x_in = fld_align(acc_ff, fsel);
            case (func_ff)
               FUNC_MUL: y_in = b_m;
               FUNC_SQR: y_in = acc_ff;
               default:  y_in = sq_ff ? acc_ff : a_m;
            endcase
            acc_in   = '0;
            cnt_in   = fld_deg(fsel);
            ops_in   = ops_ff - 11'd1;
            sq_in    = ~sq_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in = step;
            x_in   = x_ff << 1;
            cnt_in = cnt_ff - 10'd1;
            if (cnt_ff == 10'd1) begin
               state_in = (ops_ff == '0) ? S_OUT : S_KICK;
            end
         end
         S_OUT: begin
            if (rsp_hs) begin
               acc_in  = acc_ff >> WORD_BITS;
               oidx_in = oidx_ff + 5'd1;
               if (rsp_ch.result_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         field_ff <= F_K163;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            field_ff <= csr_wdata;
         end
      end
   end

   // datapath and operand stores
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      func_ff <= func_in;
      cnt_ff  <= cnt_in;
      ops_ff  <= ops_in;
      sq_ff   <= sq_in;
      err_ff  <= err_in;
      oidx_ff <= oidx_in;
      if (req_hs && req_ch.word_index < widx_type'(MAX_WORDS)) begin
         a_ff[req_ch.word_index*WORD_BITS +: WORD_BITS] <= req_ch.operand_a_word;
         b_ff[req_ch.word_index*WORD_BITS +: WORD_BITS] <= req_ch.operand_b_word;
      end
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = (state_ff == S_OUT);
   assign rsp_ch.result_word   = acc_ff[WORD_BITS-1:0];
   assign rsp_ch.result_index  = oidx_ff;
   assign rsp_ch.result_last   = (oidx_ff == fld_words(fsel) - 5'd1);
   assign rsp_ch.error         = err_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input taken while results pending");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.last_word) |=> !req_ch.ready)
      else $error("input still taken after last word");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.error) |-> (rsp_ch.result_word == '0))
      else $error("error item carries nonzero data");

   a_end_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.result_last) |=> !rsp_ch.valid)
      else $error("result run continues past last word");

endmodule
